### design/quartic_residue_character_defines.svh
// assertion macros for the quartic residue character block
// used by the top level only; expects clk and rst in scope
`ifndef QUARTIC_RESIDUE_CHARACTER_DEFINES_SVH
`define QUARTIC_RESIDUE_CHARACTER_DEFINES_SVH

// implication checked on every clock edge outside reset
`define QRC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qrc check failed");

// implication whose consequent is checked in the next cycle
`define QRC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qrc check failed");

`endif

### design/qrc_pkg.sv
// shared types and constants for the quartic residue character block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package qrc_pkg;

  localparam int NumWidth = 32;
  localparam int ExpBits  = NumWidth - 2;
  localparam int MulChains = 2 * ExpBits;
  localparam int MulCells = MulChains * NumWidth;

  typedef logic [NumWidth-1:0] num_t;

  typedef enum logic [1:0] {
    CfgModulus    = 2'd0,
    CfgUnityOne   = 2'd1,
    CfgUnityTwo   = 2'd2,
    CfgUnityThree = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic valid;
    num_t num;
    num_t rem;
  } div_item_t;

  typedef struct packed {
    logic valid;
    logic zero;
    num_t base;
    num_t x;
    num_t y;
    num_t acc;
  } mul_item_t;

endpackage

`default_nettype wire

### design/qrc_div_cell.sv
// one restoring division step: shifts in one bit of the value and reduces by the modulus
// depends on qrc_pkg
`timescale 1ns / 1ps
`default_nettype none

module qrc_div_cell import qrc_pkg::*; (
  input  wire       clk,
  input  wire       rst,
  input  num_t      modulus,
  input  div_item_t in_item,
  output div_item_t out_item
);

  logic [NumWidth:0] trial;
  logic [NumWidth:0] trial_red;

  always_comb begin
    trial = {in_item.rem, in_item.num[NumWidth-1]};
    if (trial >= {1'b0, modulus}) begin
      trial_red = trial - {1'b0, modulus};
    end else begin
      trial_red = trial;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_item.valid <= 1'b0;
    end else begin
      out_item.valid <= in_item.valid;
    end
    out_item.num <= {in_item.num[NumWidth-2:0], 1'b0};
    out_item.rem <= trial_red[NumWidth-1:0];
  end

endmodule

`default_nettype wire

### design/qrc_mul_cell.sv
// one step of a shift-and-add modular multiply: acc = 2*acc + x*ybit mod modulus
// depends on qrc_pkg
`timescale 1ns / 1ps
`default_nettype none

module qrc_mul_cell import qrc_pkg::*; (
  input  wire       clk,
  input  wire       rst,
  input  num_t      modulus,
  input  mul_item_t in_item,
  output mul_item_t out_item
);

  logic [NumWidth:0] dbl;
  logic [NumWidth:0] dbl_red;
  logic [NumWidth:0] sum;
  logic [NumWidth:0] sum_red;

  always_comb begin
    dbl = {in_item.acc, 1'b0};
    if (dbl >= {1'b0, modulus}) begin
      dbl_red = dbl - {1'b0, modulus};
    end else begin
      dbl_red = dbl;
    end
    sum = dbl_red + {1'b0, in_item.x};
    if (in_item.y[NumWidth-1] && (sum >= {1'b0, modulus})) begin
      sum_red = sum - {1'b0, modulus};
    end else if (in_item.y[NumWidth-1]) begin
      sum_red = sum;
    end else begin
      sum_red = dbl_red;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_item.valid <= 1'b0;
    end else begin
      out_item.valid <= in_item.valid;
    end
    out_item.zero <= in_item.zero;
    out_item.base <= in_item.base;
    out_item.x    <= in_item.x;
    out_item.y    <= {in_item.y[NumWidth-2:0], 1'b0};
    out_item.acc  <= sum_red[NumWidth-1:0];
  end

endmodule

`default_nettype wire

### design/quartic_residue_character.sv
// Quartic residue character of value modulo a configured prime.
// Command channel: a transaction is taken when start is high and busy is low.
// busy is high during reset and for the first cycle after it, so from then on
// a new value can enter every cycle. Each result appears for one cycle with
// done high, carrying is_zero, char_exponent and no_match; the receiver
// cannot stall it.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Write registers only while no transaction is in flight.
// The value passes through a chain of NumWidth division cells that reduces it,
// then one chain of NumWidth multiply cells per square and per conditional
// multiply of the left-to-right exponentiation, then an output register for
// the compare.
// Throughput is one transaction per cycle.
// Reset clears all valid bits in the cell chain and loads the register
// defaults (modulus 5, roots 2, 4, 3); results in flight are dropped.
// depends on qrc_pkg, qrc_div_cell, qrc_mul_cell and the defines header
`timescale 1ns / 1ps
`default_nettype none
`include "quartic_residue_character_defines.svh"

module quartic_residue_character import qrc_pkg::*; (
  input  wire        clk,
  input  wire        rst,
  input  wire        start,
  output logic       busy,
  input  wire  [31:0] value,
  output logic       done,
  output logic       is_zero,
  output logic [1:0] char_exponent,
  output logic       no_match,
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire  [1:0] cfg_index,
  input  wire  [31:0] cfg_data
);

  num_t modulus;
  num_t unity_power_one;
  num_t unity_power_two;
  num_t unity_power_three;
  num_t exp_val;
  num_t pw;
  logic small_mod;

  div_item_t div_s [0:NumWidth];
  mul_item_t mul_s [0:MulCells];
  mul_item_t cell_in [0:MulCells-1];

  assign cfg_ready = 1'b1;
  assign exp_val   = (modulus - num_t'(1)) >> 2;
  assign small_mod = (modulus < num_t'(2));

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus           <= num_t'(5);
      unity_power_one   <= num_t'(2);
      unity_power_two   <= num_t'(4);
      unity_power_three <= num_t'(3);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        CfgModulus:    modulus           <= cfg_data[NumWidth-1:0];
        CfgUnityOne:   unity_power_one   <= cfg_data[NumWidth-1:0];
        CfgUnityTwo:   unity_power_two   <= cfg_data[NumWidth-1:0];
        CfgUnityThree: unity_power_three <= cfg_data[NumWidth-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  // division chain
  always_comb begin
    div_s[0].valid = start && !busy;
    div_s[0].num   = value[NumWidth-1:0];
    div_s[0].rem   = '0;
  end

  for (genvar d = 0; d < NumWidth; d++) begin : g_div
    qrc_div_cell u_div (
      .clk      (clk),
      .rst      (rst),
      .modulus  (modulus),
      .in_item  (div_s[d]),
      .out_item (div_s[d+1])
    );
  end

  always_comb begin
    mul_s[0].valid = div_s[NumWidth].valid;
    mul_s[0].zero  = small_mod || (div_s[NumWidth].rem == '0);
    mul_s[0].base  = div_s[NumWidth].rem;
    mul_s[0].x     = '0;
    mul_s[0].y     = '0;
    mul_s[0].acc   = '0;
  end

  // exponentiation: even chains square, odd chains multiply by base or one
  for (genvar c = 0; c < MulChains; c++) begin : g_chain
    localparam int Bit = ExpBits - 1 - c / 2;
    num_t r;

    if (c == 0) begin : g_first
      assign r = num_t'(1);
    end else begin : g_rest
      assign r = mul_s[c*NumWidth].acc;
    end

    always_comb begin
      cell_in[c*NumWidth] = mul_s[c*NumWidth];
      cell_in[c*NumWidth].x   = r;
      cell_in[c*NumWidth].acc = '0;
      if ((c % 2) == 0) begin
        cell_in[c*NumWidth].y = r;
      end else if (exp_val[Bit]) begin
        cell_in[c*NumWidth].y = mul_s[c*NumWidth].base;
      end else begin
        cell_in[c*NumWidth].y = num_t'(1);
      end
    end

    for (genvar j = 0; j < NumWidth; j++) begin : g_cell
      if (j != 0) begin : g_pass
        assign cell_in[c*NumWidth+j] = mul_s[c*NumWidth+j];
      end
      qrc_mul_cell u_mul (
        .clk      (clk),
        .rst      (rst),
        .modulus  (modulus),
        .in_item  (cell_in[c*NumWidth+j]),
        .out_item (mul_s[c*NumWidth+j+1])
      );
    end
  end

  assign pw = mul_s[MulCells].acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= mul_s[MulCells].valid;
    end
    is_zero       <= mul_s[MulCells].zero;
    char_exponent <= 2'd0;
    no_match      <= 1'b0;
    if (!mul_s[MulCells].zero) begin
      if (pw == num_t'(1)) begin
        char_exponent <= 2'd0;
      end else if (pw == unity_power_one) begin
        char_exponent <= 2'd1;
      end else if (pw == unity_power_two) begin
        char_exponent <= 2'd2;
      end else if (pw == unity_power_three) begin
        char_exponent <= 2'd3;
      end else begin
        no_match <= 1'b1;
      end
    end
  end

  `QRC_ASSERT_IMPL(a_zero_excl, done, !(is_zero && no_match))
  `QRC_ASSERT_IMPL(a_zero_exp, done && is_zero, char_exponent == 2'd0)
  `QRC_ASSERT_IMPL(a_nomatch_exp, done && no_match, char_exponent == 2'd0)
  `QRC_ASSERT_NEXT(a_done_src, mul_s[MulCells].valid, done)

endmodule

`default_nettype wire
